>>> hdl/token_to_parse_record_stage_assert.svh
// Assertion macros for the token to parse record stage.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef TOKEN_TO_PARSE_RECORD_STAGE_ASSERT_SVH
`define TOKEN_TO_PARSE_RECORD_STAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttp: same-cycle check failed");
`define TTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttp: next-cycle check failed");
`else
`define TTP_ASSERT_NOW(label, ante, cons)
`define TTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hdl/ttp_pkg.sv
// Shared types and codes for the token to parse record stage.
// No dependencies; imported by every other file but the assert header.
`timescale 1ns / 1ps
package ttp_pkg;

    localparam int KIND_W      = 4;
    localparam int CHAR_W      = 8;
    // Length field of a queued command; covers lexemes up to 63 characters.
    localparam int CMD_LEN_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    // Token kinds
    localparam logic [KIND_W-1:0] TK_NEWLINE = 4'd0;
    localparam logic [KIND_W-1:0] TK_CLOSE   = 4'd1;
    localparam logic [KIND_W-1:0] TK_QUOTE   = 4'd2;
    localparam logic [KIND_W-1:0] TK_CHAR    = 4'd3;
    localparam logic [KIND_W-1:0] TK_OPEN    = 4'd4;
    localparam logic [KIND_W-1:0] TK_DIGIT   = 4'd5;
    localparam logic [KIND_W-1:0] TK_PERIOD  = 4'd6;
    localparam logic [KIND_W-1:0] TK_PLUS    = 4'd7;
    localparam logic [KIND_W-1:0] TK_MINUS   = 4'd8;
    localparam logic [KIND_W-1:0] TK_STAR    = 4'd9;
    localparam logic [KIND_W-1:0] TK_SLASH   = 4'd10;
    localparam logic [KIND_W-1:0] TK_SPACE   = 4'd11;
    localparam logic [KIND_W-1:0] TK_EQUALS  = 4'd12;
    localparam logic [KIND_W-1:0] TK_OTHER   = 4'd13;
    localparam logic [KIND_W-1:0] TK_END     = 4'd14;

    // Record kinds
    localparam logic [KIND_W-1:0] RK_EMPTY      = 4'd0;
    localparam logic [KIND_W-1:0] RK_STRING     = 4'd1;
    localparam logic [KIND_W-1:0] RK_NAME       = 4'd2;
    localparam logic [KIND_W-1:0] RK_NUMBER     = 4'd3;
    localparam logic [KIND_W-1:0] RK_VAR        = 4'd4;
    localparam logic [KIND_W-1:0] RK_CALL       = 4'd5;
    localparam logic [KIND_W-1:0] RK_ADD        = 4'd6;
    localparam logic [KIND_W-1:0] RK_SUB        = 4'd7;
    localparam logic [KIND_W-1:0] RK_MUL        = 4'd8;
    localparam logic [KIND_W-1:0] RK_DIV        = 4'd9;
    localparam logic [KIND_W-1:0] RK_OPEN       = 4'd10;
    localparam logic [KIND_W-1:0] RK_CLOSE      = 4'd11;
    localparam logic [KIND_W-1:0] RK_LINE_END   = 4'd12;
    localparam logic [KIND_W-1:0] RK_STREAM_END = 4'd13;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    // Mode codes equal the record kind of the lexeme they collect.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NAME   = 2'd2,
        MODE_NUMBER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_BUF   = 2'd1,
        BK_TRAIL = 2'd2
    } bk_state_t;

    // One token's worth of output: an optional buffered record, then an
    // optional single-word trailer record.
    typedef struct packed {
        logic                  has_buf;
        logic [KIND_W-1:0]     buf_kind;
        logic                  buf_bank;
        logic [CMD_LEN_W-1:0]  buf_len;
        logic                  buf_ovf;
        logic                  has_trail;
        logic [KIND_W-1:0]     trail_kind;
        logic [CHAR_W-1:0]     trail_char;
        logic                  trail_valid;
    } cmd_t;

    typedef struct packed {
        logic free_en;
        logic free_bank;
        logic reading;
        logic read_bank;
    } bk_stat_t;

    // Characters of the declaration keyword "var".
    function automatic logic [CHAR_W-1:0] var_char(input logic [1:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            2'd0:    c = 8'h76;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/ttp_if.sv
// Stream interfaces for the token input and the record output.
// Depends on ttp_pkg for field widths.
`timescale 1ns / 1ps
interface ttp_token_if;
    import ttp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] token_char;

    modport source (output valid, output token_kind, output token_char, input ready);
    modport sink   (input valid, input token_kind, input token_char, output ready);
endinterface

interface ttp_record_if;
    import ttp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] record_kind;
    logic [CHAR_W-1:0] text_char;
    logic              char_valid;
    logic              record_last;
    logic              text_overflow;
    logic              run_last;

    modport source (output valid, output record_kind, output text_char, output char_valid,
                    output record_last, output text_overflow, output run_last, input ready);
    modport sink   (input valid, input record_kind, input text_char, input char_valid,
                    input record_last, input text_overflow, input run_last, output ready);
endinterface

>>> hdl/ttp_front.sv
// Front end: accepts tokens, tracks the lexer mode and fills the lexeme banks.
// Depends on ttp_pkg and ttp_if; feeds ttp_queue and writes into ttp_back.
`timescale 1ns / 1ps
module ttp_front #(
    parameter int MAX_LEXEME = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    ttp_token_if.sink         tokens,
    input  logic              q_ready,
    output logic              push,
    output ttp_pkg::cmd_t     push_cmd,
    output logic              wr_en,
    output logic              wr_bank,
    output logic [$clog2(MAX_LEXEME)-1:0] wr_idx,
    output logic [ttp_pkg::CHAR_W-1:0]    wr_data,
    input  ttp_pkg::bk_stat_t bk_stat
);
    import ttp_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEXEME + 1);
    localparam int IDX_W = $clog2(MAX_LEXEME);

    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next, base_len;
    logic              ovf_reg, ovf_next, base_ovf;
    logic              vm_reg, vm_next, base_vm;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;

    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              accept, room, is_var;
    logic              emit, clr, run_idle, app, trail, tvalid;
    logic [KIND_W-1:0] bkind, tkind;
    logic [CHAR_W-1:0] tchar;

    assign kind   = tokens.token_kind;
    assign ch     = tokens.token_char;
    assign is_var = !ovf_reg && (len_reg == LEN_W'(3)) && vm_reg;

    // Classify the token against the current mode.
    always_comb
    begin
        emit      = 1'b0;
        bkind     = RK_EMPTY;
        clr       = 1'b0;
        run_idle  = 1'b0;
        app       = 1'b0;
        trail     = 1'b0;
        tkind     = RK_EMPTY;
        tchar     = '0;
        tvalid    = 1'b0;
        mode_next = mode_reg;

        if (kind == TK_END)
        begin
            emit  = (mode_reg != MODE_IDLE);
            bkind = {2'b00, mode_reg};
            clr   = 1'b1;
            trail = 1'b1;
            tkind = RK_STREAM_END;
        end
        else if (kind == TK_NEWLINE && mode_reg != MODE_STRING)
        begin
            emit  = 1'b1;
            bkind = {2'b00, mode_reg};
            clr   = 1'b1;
            trail = 1'b1;
            tkind = RK_LINE_END;
        end
        else if (mode_reg == MODE_IDLE)
        begin
            run_idle = 1'b1;
        end
        else if (kind == TK_CLOSE)
        begin
            emit  = 1'b1;
            bkind = {2'b00, mode_reg};
            clr   = 1'b1;
            trail = 1'b1;
            tkind = RK_CLOSE;
        end
        else
        begin
            unique case (mode_reg)
                MODE_STRING:
                begin
                    if (kind == TK_QUOTE)
                    begin
                        emit  = 1'b1;
                        bkind = RK_STRING;
                        clr   = 1'b1;
                    end
                    else
                    begin
                        app = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    if (kind == TK_CHAR)
                    begin
                        app = 1'b1;
                    end
                    else if (kind == TK_OPEN)
                    begin
                        emit  = 1'b1;
                        bkind = RK_CALL;
                        clr   = 1'b1;
                        trail = 1'b1;
                        tkind = RK_OPEN;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        bkind    = is_var ? RK_VAR : RK_NAME;
                        clr      = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (kind == TK_DIGIT || kind == TK_PERIOD)
                    begin
                        app = 1'b1;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        bkind    = RK_NUMBER;
                        clr      = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (clr)
            mode_next = MODE_IDLE;

        // Idle handling, also applied to a token that ended a name or number.
        if (run_idle)
        begin
            case (kind) inside
                TK_PLUS:
                begin
                    trail = 1'b1; tkind = RK_ADD; tchar = CH_PLUS; tvalid = 1'b1;
                end
                TK_MINUS:
                begin
                    trail = 1'b1; tkind = RK_SUB; tchar = CH_MINUS; tvalid = 1'b1;
                end
                TK_STAR:
                begin
                    trail = 1'b1; tkind = RK_MUL; tchar = CH_STAR; tvalid = 1'b1;
                end
                TK_SLASH:
                begin
                    trail = 1'b1; tkind = RK_DIV; tchar = CH_SLASH; tvalid = 1'b1;
                end
                TK_CLOSE:
                begin
                    trail = 1'b1; tkind = RK_CLOSE;
                end
                TK_QUOTE:
                begin
                    mode_next = MODE_STRING;
                end
                TK_CHAR:
                begin
                    app       = 1'b1;
                    mode_next = MODE_NAME;
                end
                TK_DIGIT:
                begin
                    app       = 1'b1;
                    mode_next = MODE_NUMBER;
                end
                TK_OPEN, TK_PERIOD, TK_SPACE, TK_EQUALS, TK_OTHER:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Lexeme bookkeeping; an append after an emit lands in the fresh bank.
    always_comb
    begin
        base_len  = clr ? '0 : len_reg;
        base_ovf  = clr ? 1'b0 : ovf_reg;
        base_vm   = clr ? 1'b1 : vm_reg;
        bank_next = emit ? ~bank_reg : bank_reg;
        room      = base_len < LEN_W'(MAX_LEXEME);

        wr_en   = accept && app && room;
        wr_bank = bank_next;
        wr_idx  = base_len[IDX_W-1:0];
        wr_data = ch;

        len_next = base_len;
        ovf_next = base_ovf;
        vm_next  = base_vm;
        if (app)
        begin
            if (room)
            begin
                len_next = base_len + LEN_W'(1);
                if (base_len < LEN_W'(3))
                    vm_next = base_vm && (ch == var_char(base_len[1:0]));
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        busy_next = busy_reg;
        if (bk_stat.free_en)
            busy_next[bk_stat.free_bank] = 1'b0;
        if (accept && emit)
            busy_next[bank_reg] = 1'b1;
    end

    // Hold the token while the command queue is full or the bank it touches is still being streamed.
    assign tokens.ready = q_ready && !busy_reg[bank_reg]
                          && !(emit && app && busy_reg[~bank_reg]);
    assign accept = tokens.valid && tokens.ready;
    assign push   = accept && (emit || trail);

    always_comb
    begin
        push_cmd.has_buf     = emit;
        push_cmd.buf_kind    = bkind;
        push_cmd.buf_bank    = bank_reg;
        push_cmd.buf_len     = CMD_LEN_W'(len_reg);
        push_cmd.buf_ovf     = ovf_reg;
        push_cmd.has_trail   = trail;
        push_cmd.trail_kind  = tkind;
        push_cmd.trail_char  = tchar;
        push_cmd.trail_valid = tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            vm_reg   <= 1'b1;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                ovf_reg  <= ovf_next;
                vm_reg   <= vm_next;
                bank_reg <= bank_next;
            end
        end
    end

endmodule

>>> hdl/ttp_queue.sv
// Short command queue between the front end and the back end.
// Depends on ttp_pkg for the command type.
`timescale 1ns / 1ps
module ttp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ttp_pkg::cmd_t push_cmd,
    output logic          ready,
    input  logic          pop,
    output ttp_pkg::cmd_t head,
    output logic          head_valid
);
    import ttp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign ready      = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

>>> hdl/ttp_back.sv
// Back end: holds the two lexeme banks and streams each command as record words.
// Depends on ttp_pkg and ttp_if; fed by ttp_queue and ttp_front.
`timescale 1ns / 1ps
module ttp_back #(
    parameter int MAX_LEXEME = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ttp_pkg::cmd_t                 head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic                          wr_en,
    input  logic                          wr_bank,
    input  logic [$clog2(MAX_LEXEME)-1:0] wr_idx,
    input  logic [ttp_pkg::CHAR_W-1:0]    wr_data,
    output ttp_pkg::bk_stat_t             stat,
    ttp_record_if.source                  records
);
    import ttp_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEXEME);

    logic [CHAR_W-1:0] lexeme_mem [2][MAX_LEXEME];

    bk_state_t         state_reg, state_next;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [CHAR_W-1:0] char_reg, rd_data_reg;
    logic              from_mem_reg, cvalid_reg, rlast_reg, ovf_reg, runlast_reg;

    logic              load, out_load, rd_en, buf_last;
    logic [KIND_W-1:0] kind_next;
    logic [CHAR_W-1:0] char_next;
    logic              from_mem_next, cvalid_next, rlast_next, ovf_next, runlast_next;

    assign load     = !out_valid_reg || records.ready;
    assign buf_last = (cmd_reg.buf_len == '0)
                      || (CMD_LEN_W'(idx_reg) + CMD_LEN_W'(1) == cmd_reg.buf_len);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        pop           = 1'b0;
        out_load      = 1'b0;
        rd_en         = 1'b0;
        kind_next     = kind_reg;
        char_next     = '0;
        from_mem_next = 1'b0;
        cvalid_next   = 1'b0;
        rlast_next    = 1'b1;
        ovf_next      = 1'b0;
        runlast_next  = 1'b1;
        stat.free_en  = 1'b0;
        stat.free_bank = cmd_reg.buf_bank;
        stat.reading  = (state_reg == BK_BUF);
        stat.read_bank = cmd_reg.buf_bank;

        unique case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                if (head_valid)
                begin
                    pop        = 1'b1;
                    state_next = head.has_buf ? BK_BUF : BK_TRAIL;
                end
            end
            BK_BUF:
            begin
                if (load)
                begin
                    out_load      = 1'b1;
                    rd_en         = (cmd_reg.buf_len != '0);
                    kind_next     = cmd_reg.buf_kind;
                    from_mem_next = (cmd_reg.buf_len != '0);
                    cvalid_next   = (cmd_reg.buf_len != '0);
                    rlast_next    = buf_last;
                    ovf_next      = cmd_reg.buf_ovf;
                    runlast_next  = buf_last && !cmd_reg.has_trail;
                    if (buf_last)
                    begin
                        stat.free_en = 1'b1;
                        state_next   = cmd_reg.has_trail ? BK_TRAIL : BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            BK_TRAIL:
            begin
                if (load)
                begin
                    out_load    = 1'b1;
                    kind_next   = cmd_reg.trail_kind;
                    char_next   = cmd_reg.trail_char;
                    cvalid_next = cmd_reg.trail_valid;
                    state_next  = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            lexeme_mem[wr_bank][wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= lexeme_mem[cmd_reg.buf_bank][idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head;
        if (out_load)
        begin
            kind_reg     <= kind_next;
            char_reg     <= char_next;
            from_mem_reg <= from_mem_next;
            cvalid_reg   <= cvalid_next;
            rlast_reg    <= rlast_next;
            ovf_reg      <= ovf_next;
            runlast_reg  <= runlast_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (records.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign records.valid         = out_valid_reg;
    assign records.record_kind   = kind_reg;
    assign records.text_char     = from_mem_reg ? rd_data_reg : char_reg;
    assign records.char_valid    = cvalid_reg;
    assign records.record_last   = rlast_reg;
    assign records.text_overflow = ovf_reg;
    assign records.run_last      = runlast_reg;

endmodule

>>> hdl/token_to_parse_record_stage.sv
// Token to parse record stage: groups lexer tokens into parse records.
// Depends on ttp_pkg, ttp_if, ttp_front, ttp_queue, ttp_back and the assert header.
//
// Channels: tokens (sink) carries token_kind and token_char; records (source)
// carries one word per record character plus record_kind, char_valid,
// record_last, text_overflow and run_last. Both use valid/ready; a word moves
// on a clock edge with valid and ready high.
// Rate: a token that only extends a lexeme, or produces nothing, is taken
// whenever tokens.ready is high, and so is a token that closes a record; the
// back end then fetches its command, streams one word per buffered character
// (one for an empty record) and one for a trailing marker word. The back
// end's word-per-cycle streaming, while the records receiver is ready, sets
// the sustained rate. A token's first result word passes the queue entry,
// the back end's command register and its output register.
// Lexemes collect in one of two banks so the front end keeps taking tokens
// while the previous record streams out; it stalls only when the bank it needs
// is still being streamed or the two-entry command queue is full.
// Reset: mode idle, lexeme empty, queue empty, no output word pending.
// A stalled records receiver holds the output word; the queue then fills and
// tokens.ready drops.
`timescale 1ns / 1ps
module token_to_parse_record_stage #(
    parameter int MAX_LEXEME = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ttp_token_if.sink     tokens,
    ttp_record_if.source  records
);
    import ttp_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEXEME);

    logic              q_ready, q_push, q_pop, q_head_valid;
    cmd_t              q_push_cmd, q_head;
    logic              wr_en, wr_bank;
    logic [IDX_W-1:0]  wr_idx;
    logic [CHAR_W-1:0] wr_data;
    bk_stat_t          bk_stat;

    // Classify tokens and fill the lexeme banks.
    ttp_front #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .tokens   (tokens),
        .q_ready  (q_ready),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .wr_en    (wr_en),
        .wr_bank  (wr_bank),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .bk_stat  (bk_stat)
    );

    // Decouple the two sides.
    ttp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .ready      (q_ready),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    // Stream records out, one word per cycle while the receiver is ready.
    ttp_back #(
        .MAX_LEXEME (MAX_LEXEME)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .wr_en      (wr_en),
        .wr_bank    (wr_bank),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .stat       (bk_stat),
        .records    (records)
    );

`include "token_to_parse_record_stage_assert.svh"

    // A lexeme write only ever comes from an accepted token.
    `TTP_ASSERT_NOW(a_wr_on_accept, wr_en, tokens.valid && tokens.ready)
    // Never write into the bank that is streaming out.
    `TTP_ASSERT_NOW(a_wr_bank_free, wr_en && bk_stat.reading, wr_bank != bk_stat.read_bank)
    // Commands are pushed only into a queue with room.
    `TTP_ASSERT_NOW(a_push_room, q_push, q_ready)
    // Freeing a bank ends the buffered part of the command.
    `TTP_ASSERT_NEXT(a_free_ends_read, bk_stat.free_en, !bk_stat.reading)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for token_to_parse_record_stage: drives token words,
// predicts record words from its own model of the stage (or takes typed-in ones) and checks them in order.
// Depends on ttp_pkg, the ttp_if stream interfaces and the stage RTL.
module testbench;
    import ttp_pkg::*;

    localparam int LEXEME_CAP   = 16;
    localparam int LEX_IDX_W    = $clog2(LEXEME_CAP);
    localparam int RANDOM_ITEMS = 350;
    localparam int CALM_ITEMS   = 50;     // last stretch of the run with no idling
    localparam int CHECKED      = -1;     // row expectation comes from the predictor
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    // One record word as it leaves the stage, fields in port order.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic              char_valid;
        logic              record_last;
        logic              overflow;
        logic              run_last;
    } rec_word_t;

    // One row of the directed table: a token, plus an optional typed-in result.
    // typed_n is CHECKED, or the number of typed words (0 or 1).
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        int                typed_n;
        rec_word_t         typed_word;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    ttp_token_if  tok_ch();
    ttp_record_if rec_ch();

    token_to_parse_record_stage #(
        .MAX_LEXEME(LEXEME_CAP)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .tokens  (tok_ch),
        .records (rec_ch)
    );

    // Lexer-side state of the predicted stage.
    mode_t             lex_mode = MODE_IDLE;
    logic [CHAR_W-1:0] lex_buf [LEXEME_CAP];
    int                lex_len  = 0;
    logic              lex_ovf  = 1'b0;

    rec_word_t token_words[$];     // words caused by the token being predicted
    rec_word_t pending_words[$];   // words still owed by the stage, oldest first
    stim_row_t directed_rows[$];

    int        typed_n = CHECKED;
    rec_word_t typed_word = '0;

    int errors         = 0;
    int tokens_taken   = 0;
    int tokens_counted = 0;        // tokens that did more than get ignored
    int words_checked  = 0;
    int records_seen   = 0;
    int cut_records    = 0;
    int var_records    = 0;
    int cycles         = 0;

    bit calm  = 1'b0;              // set for the last stretch: no idling at all
    bit quiet = 1'b0;              // per sequence: a stretch without idling
    int stall_left;

    // ------------------------------------------------------------------
    // Predictor of the stage
    // ------------------------------------------------------------------
    function automatic void clear_lexeme();
        lex_mode = MODE_IDLE;
        lex_len  = 0;
        lex_ovf  = 1'b0;
    endfunction

    function automatic void push_word(input logic [KIND_W-1:0] kind,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic cv, input logic last,
                                      input logic ovf);
        rec_word_t w;
        w = '{kind, ch, cv, last, ovf, 1'b0};
        token_words = {token_words, w};
    endfunction

    // Append to the lexeme; past capacity drop the character and flag the cut.
    function automatic void append_char(input logic [CHAR_W-1:0] ch);
        if (lex_len < LEXEME_CAP)
        begin
            lex_buf[LEX_IDX_W'(lex_len)] = ch;
            lex_len++;
        end
        else
        begin
            lex_ovf = 1'b1;
        end
    endfunction

    // Stream the buffered lexeme as one record; an empty one is a single word.
    function automatic void emit_lexeme(input logic [KIND_W-1:0] kind);
        int i;
        if (lex_len == 0)
        begin
            push_word(kind, '0, 1'b0, 1'b1, lex_ovf);
        end
        else
        begin
            for (i = 0; i < lex_len; i++)
                push_word(kind, lex_buf[LEX_IDX_W'(i)], 1'b1, i == lex_len - 1, lex_ovf);
        end
    endfunction

    function automatic logic spells_var();
        return !lex_ovf && lex_len == 3 && lex_buf[0] == "v" && lex_buf[1] == "a" &&
               lex_buf[2] == "r";
    endfunction

    function automatic void idle_token(input logic [KIND_W-1:0] kind,
                                       input logic [CHAR_W-1:0] ch);
        case (kind)
            TK_PLUS:
            begin
                push_word(RK_ADD, CH_PLUS, 1'b1, 1'b1, 1'b0);
                clear_lexeme();
            end
            TK_MINUS:
            begin
                push_word(RK_SUB, CH_MINUS, 1'b1, 1'b1, 1'b0);
                clear_lexeme();
            end
            TK_STAR:
            begin
                push_word(RK_MUL, CH_STAR, 1'b1, 1'b1, 1'b0);
                clear_lexeme();
            end
            TK_SLASH:
            begin
                push_word(RK_DIV, CH_SLASH, 1'b1, 1'b1, 1'b0);
                clear_lexeme();
            end
            TK_QUOTE:
            begin
                lex_mode = MODE_STRING;
            end
            TK_CHAR:
            begin
                append_char(ch);
                lex_mode = MODE_NAME;
            end
            TK_DIGIT:
            begin
                append_char(ch);
                lex_mode = MODE_NUMBER;
            end
            TK_CLOSE:
            begin
                push_word(RK_CLOSE, '0, 1'b0, 1'b1, 1'b0);
                clear_lexeme();
            end
            TK_SPACE:
            begin
                clear_lexeme();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Advance the predictor by one accepted token and queue the words it owes.
    function automatic void predict_token(input logic [KIND_W-1:0] kind,
                                          input logic [CHAR_W-1:0] ch);
        mode_t mode_before;
        mode_before = lex_mode;
        token_words.delete();

        if (kind == TK_END)
        begin
            if (lex_mode != MODE_IDLE)
                emit_lexeme({2'b00, lex_mode});
            clear_lexeme();
            push_word(RK_STREAM_END, '0, 1'b0, 1'b1, 1'b0);
        end
        else if (kind == TK_NEWLINE && lex_mode != MODE_STRING)
        begin
            emit_lexeme({2'b00, lex_mode});
            clear_lexeme();
            push_word(RK_LINE_END, '0, 1'b0, 1'b1, 1'b0);
        end
        else if (lex_mode == MODE_IDLE)
        begin
            idle_token(kind, ch);
        end
        else if (kind == TK_CLOSE)
        begin
            emit_lexeme({2'b00, lex_mode});
            clear_lexeme();
            push_word(RK_CLOSE, '0, 1'b0, 1'b1, 1'b0);
        end
        else if (lex_mode == MODE_STRING)
        begin
            if (kind == TK_QUOTE)
            begin
                emit_lexeme(RK_STRING);
                clear_lexeme();
            end
            else
            begin
                append_char(ch);
            end
        end
        else if (lex_mode == MODE_NAME)
        begin
            if (kind == TK_CHAR)
            begin
                append_char(ch);
            end
            else if (kind == TK_OPEN)
            begin
                emit_lexeme(RK_CALL);
                clear_lexeme();
                push_word(RK_OPEN, '0, 1'b0, 1'b1, 1'b0);
            end
            else
            begin
                emit_lexeme(spells_var() ? RK_VAR : RK_NAME);
                clear_lexeme();
                idle_token(kind, ch);
            end
        end
        else
        begin
            if (kind == TK_DIGIT || kind == TK_PERIOD)
            begin
                append_char(ch);
            end
            else
            begin
                emit_lexeme(RK_NUMBER);
                clear_lexeme();
                idle_token(kind, ch);
            end
        end

        if (token_words.size() > 0)
            token_words[token_words.size() - 1].run_last = 1'b1;
        if (token_words.size() > 0 || mode_before != MODE_IDLE || lex_mode != MODE_IDLE)
            tokens_counted++;
        tokens_taken++;

        // A typed-in row replaces the predicted words with its own.
        if (typed_n != CHECKED)
        begin
            token_words.delete();
            if (typed_n == 1)
                token_words = {token_words, typed_word};
        end
        pending_words = {pending_words, token_words};
    endfunction

    // Compare one accepted record word with the oldest expectation.
    function automatic void check_word(input rec_word_t got);
        rec_word_t want;
        words_checked++;
        if (got.record_last)
        begin
            records_seen++;
            if (got.overflow)
                cut_records++;
            if (got.kind == RK_VAR)
                var_records++;
        end
        if (pending_words.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("[%0t] unexpected word: kind %0d char %02h cv %0d last %0d ovf %0d run %0d",
                         $time, got.kind, got.ch, got.char_valid, got.record_last,
                         got.overflow, got.run_last);
        end
        else
        begin
            want = pending_words.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"[%0t] mismatch: expected kind %0d char %02h cv %0d last %0d ",
                              "ovf %0d run %0d, got kind %0d char %02h cv %0d last %0d ",
                              "ovf %0d run %0d"},
                             $time, want.kind, want.ch, want.char_valid, want.record_last,
                             want.overflow, want.run_last, got.kind, got.ch, got.char_valid,
                             got.record_last, got.overflow, got.run_last);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted token, check every accepted word.
    // Both sides are sampled on the rising edge, before the stage updates.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_ch.valid && tok_ch.ready)
                predict_token(tok_ch.token_kind, tok_ch.token_char);
            if (rec_ch.valid && rec_ch.ready)
                check_word({rec_ch.record_kind, rec_ch.text_char, rec_ch.char_valid,
                            rec_ch.record_last, rec_ch.text_overflow, rec_ch.run_last});
        end
    end

    // Drop the run if it hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d words still owed",
                     $time, cycles, pending_words.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Record receiver: stall in random bursts; no new burst starts in a quiet or calm stretch.
    // ------------------------------------------------------------------
    initial
    begin
        rec_ch.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rec_ch.ready = 1'b0;
            end
            else if (!calm && !quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left   = $urandom_range(1, 17) - 1;
                rec_ch.ready = 1'b0;
            end
            else
            begin
                rec_ch.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Token sender
    // ------------------------------------------------------------------
    task automatic add_row(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                           input int tn, input rec_word_t tw);
        stim_row_t row;
        row = '{kind, ch, tn, tw};
        directed_rows = {directed_rows, row};
    endtask

    // Entered and left on a falling edge. Hold valid high into the next token
    // when there is no gap, so valid never drops and rises in one step.
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                              input int tn, input rec_word_t tw);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
        begin
            tok_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        tok_ch.valid      = 1'b1;
        tok_ch.token_kind = kind;
        tok_ch.token_char = ch;
        typed_n           = tn;
        typed_word        = tw;
        do
            @(posedge clk);
        while (!tok_ch.ready);
        @(negedge clk);
    endtask

    task automatic send(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch);
        send_token(kind, ch, CHECKED, '0);
    endtask

    // Hold the token side until the stage owes nothing more.
    task automatic hold_until_drained();
        tok_ch.valid = 1'b0;
        while (pending_words.size() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly short lexemes; a few fill the buffer or run past it and force the cut.
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 5);
        else if (r < 95)
            return $urandom_range(6, 15);
        return $urandom_range(LEXEME_CAP, LEXEME_CAP + 4);
    endfunction

    function automatic logic [CHAR_W-1:0] any_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] name_char();
        if ($urandom_range(0, 7) == 0)
            return any_byte();
        return CHAR_W'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char();
        if ($urandom_range(0, 7) == 0)
            return any_byte();
        return CHAR_W'("0" + $urandom_range(0, 9));
    endfunction

    // A token that can end a name or number (digit and period end a name only), kind 15 included.
    function automatic logic [KIND_W-1:0] pick_terminator();
        logic [KIND_W-1:0] k;
        case ($urandom_range(0, 14))
            0:       k = TK_SPACE;
            1:       k = TK_OPEN;
            2:       k = TK_CLOSE;
            3:       k = TK_NEWLINE;
            4:       k = TK_END;
            5:       k = TK_PLUS;
            6:       k = TK_MINUS;
            7:       k = TK_STAR;
            8:       k = TK_SLASH;
            9:       k = TK_EQUALS;
            10:      k = TK_OTHER;
            11:      k = TK_PERIOD;
            12:      k = TK_QUOTE;
            13:      k = TK_DIGIT;
            default: k = 4'hF;
        endcase
        return k;
    endfunction

    // One well-formed sequence with random content, or a burst of noise.
    task automatic send_sequence();
        int pick;
        int len;
        int i;
        int r;
        logic [KIND_W-1:0] k;
        pick  = $urandom_range(0, 99);
        len   = pick_length();
        quiet = ($urandom_range(0, 3) == 0);
        if (pick < 30)
        begin
            // bare name, now and then the declaration keyword
            if ($urandom_range(0, 3) == 0)
            begin
                send(TK_CHAR, "v");
                send(TK_CHAR, "a");
                send(TK_CHAR, "r");
            end
            else
            begin
                for (i = 0; i < len; i++)
                    send(TK_CHAR, name_char());
            end
            send(pick_terminator(), any_byte());
        end
        else if (pick < 50)
        begin
            send(TK_DIGIT, digit_char());
            for (i = 1; i < len; i++)
                send($urandom_range(0, 4) == 0 ? TK_PERIOD : TK_DIGIT, digit_char());
            send(pick_terminator(), any_byte());
        end
        else if (pick < 70)
        begin
            // quoted string: any token but quote, close and end is text
            send(TK_QUOTE, any_byte());
            if ($urandom_range(0, 7) == 0)
                len = 0;
            for (i = 0; i < len; i++)
            begin
                do
                    k = KIND_W'($urandom_range(0, 15));
                while (k == TK_QUOTE || k == TK_CLOSE || k == TK_END);
                send(k, any_byte());
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                send(TK_QUOTE, any_byte());
            else if (r < 85)
                send(TK_CLOSE, any_byte());
            else
                send(TK_END, any_byte());
        end
        else if (pick < 85)
        begin
            // operators and punctuation between lexemes
            for (i = 0; i < $urandom_range(1, 4); i++)
            begin
                case ($urandom_range(0, 6))
                    0:       k = TK_PLUS;
                    1:       k = TK_MINUS;
                    2:       k = TK_STAR;
                    3:       k = TK_SLASH;
                    4:       k = TK_CLOSE;
                    5:       k = TK_NEWLINE;
                    default: k = TK_OPEN;
                endcase
                send(k, any_byte());
            end
        end
        else
        begin
            for (i = 0; i < $urandom_range(1, 3); i++)
                send(KIND_W'($urandom_range(0, 15)), any_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int base;
        bit pressed;

        tok_ch.valid      = 1'b0;
        tok_ch.token_kind = TK_NEWLINE;
        tok_ch.token_char = '0;
        pressed           = 1'b0;

        // Directed table. Single-word and silent rows at its head carry their result
        // typed in; the rest go through the predictor.
        add_row(TK_END,     8'h00, 1, '{RK_STREAM_END, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1});
        add_row(TK_NEWLINE, 8'hFF, CHECKED, '0);      // empty record, then line end
        add_row(TK_PLUS,    8'h00, 1, '{RK_ADD, CH_PLUS, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(TK_MINUS,   8'h00, 1, '{RK_SUB, CH_MINUS, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(TK_STAR,    8'hFF, 1, '{RK_MUL, CH_STAR, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(TK_SLASH,   8'h55, 1, '{RK_DIV, CH_SLASH, 1'b1, 1'b1, 1'b0, 1'b1});
        add_row(TK_CLOSE,   8'hAA, 1, '{RK_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1});
        // tokens that do nothing in idle
        add_row(TK_OPEN,    8'h28, 0, '0);
        add_row(TK_PERIOD,  8'h2E, 0, '0);
        add_row(TK_SPACE,   8'h20, 0, '0);
        add_row(4'hF,       8'hFF, 0, '0);
        // declaration keyword ended by a space
        add_row(TK_CHAR,    "v",   CHECKED, '0);
        add_row(TK_CHAR,    "a",   CHECKED, '0);
        add_row(TK_CHAR,    "r",   CHECKED, '0);
        add_row(TK_SPACE,   8'h20, CHECKED, '0);
        // name followed by open paren: call, then open
        add_row(TK_CHAR,    "f",   CHECKED, '0);
        add_row(TK_OPEN,    8'h28, CHECKED, '0);
        // number with extreme bytes, closed by a paren
        add_row(TK_DIGIT,   8'h00, CHECKED, '0);
        add_row(TK_PERIOD,  8'hFF, CHECKED, '0);
        add_row(TK_CLOSE,   8'h29, CHECKED, '0);
        // newline kept inside a string, then an empty string
        add_row(TK_QUOTE,   8'h22, CHECKED, '0);
        add_row(TK_NEWLINE, 8'h0A, CHECKED, '0);
        add_row(TK_QUOTE,   8'h22, CHECKED, '0);
        add_row(TK_QUOTE,   8'h22, CHECKED, '0);
        add_row(TK_QUOTE,   8'h22, CHECKED, '0);
        // end token flushes a pending name without the keyword check
        add_row(TK_CHAR,    "x",   CHECKED, '0);
        add_row(TK_END,     8'h00, CHECKED, '0);

        // Hold reset, then release it on a falling edge.
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_token(directed_rows[i].kind, directed_rows[i].ch,
                       directed_rows[i].typed_n, directed_rows[i].typed_word);
        hold_until_drained();

        // Random part. Pause once mid-run until the stage owes nothing, and
        // turn all idling off for the final stretch.
        base = tokens_taken;
        while (tokens_taken - base < RANDOM_ITEMS)
        begin
            calm = (tokens_taken - base >= RANDOM_ITEMS - CALM_ITEMS);
            send_sequence();
            if (!pressed && tokens_taken - base >= RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
                pressed = 1'b1;
            end
        end
        calm  = 1'b1;
        quiet = 1'b1;

        // Drain: wait for every owed word, then watch a while for strays.
        tok_ch.valid = 1'b0;
        while (pending_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d tokens taken (%0d with effect), %0d words in %0d records",
                 tokens_taken, tokens_counted, words_checked, records_seen);
        $display("summary: %0d cut records, %0d declarations, %0d errors",
                 cut_records, var_records, errors);
        if (errors == 0 && pending_words.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
